// ===== hdl/bblur_pkg.sv =====
package bblur_pkg;

    localparam int WIDTH_REG_W = 11;
    localparam int HEIGHT_W    = 13;
    localparam int CFG_DATA_W  = 13;
    localparam int ROW_W       = 14;
    localparam int SUM_W       = 12;
    localparam int CNT_W       = 4;
    localparam int NUM_W       = 13;
    localparam int QUO_W       = 8;

    localparam logic [WIDTH_REG_W-1:0] WIDTH_RESET  = 11'd1024;
    localparam logic [HEIGHT_W-1:0]    HEIGHT_RESET = 13'd768;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    typedef enum logic {
        OP_PIXEL = 1'b0,
        OP_DRAIN = 1'b1
    } op_t;

    typedef enum logic {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        op_t    op;
        pixel_t px;
    } req_t;

    typedef struct packed {
        pixel_t px;
        logic   frame_end;
    } result_t;

    typedef struct packed {
        logic [2:0][SUM_W-1:0] sum;
        logic [CNT_W-1:0]      cnt;
    } div_req_t;

endpackage

// ===== hdl/bblur_fifo.sv =====
module bblur_fifo #(
    parameter int WIDTH = 25,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);
    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] data_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [AW:0]      count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == (AW+1)'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = data_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + AW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + AW'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + (AW+1)'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - (AW+1)'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            data_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ===== hdl/bblur_front.sv =====
module bblur_front #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          clear,
    input  logic [$clog2(MAX_WIDTH):0]    eff_w,
    input  logic [bblur_pkg::HEIGHT_W-1:0] eff_h,
    input  logic                          push,
    input  bblur_pkg::op_t                opcode,
    input  bblur_pkg::pixel_t             px,
    output logic                          full,
    input  logic                          q_full,
    output logic                          q_push,
    output bblur_pkg::req_t               q_data
);
    import bblur_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = CW + 1;

    typedef enum logic [1:0] {
        MODE_FILL  = 2'b01,
        MODE_DRAIN = 2'b10
    } mode_t;

    mode_t               mode_reg, mode_next;
    logic [CW-1:0]       col_reg, col_next;
    logic [HEIGHT_W-1:0] row_reg, row_next;
    logic [WW-1:0]       drain_reg, drain_next;
    logic                accept;
    logic                last_px;

    assign full    = q_full;
    assign accept  = push && !q_full;
    assign last_px = (row_reg == eff_h - HEIGHT_W'(1))
                  && ({1'b0, col_reg} == eff_w - WW'(1));

    always_comb
    begin
        mode_next  = mode_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        drain_next = drain_reg;
        q_push     = 1'b0;
        q_data     = '{op: OP_PIXEL, px: px};
        unique case (mode_reg)
            MODE_FILL:
            begin
                // A drain request that arrives while a frame is coming in has no effect.
                if (accept && opcode == OP_PIXEL)
                begin
                    q_push = 1'b1;
                    if (last_px)
                    begin
                        mode_next  = MODE_DRAIN;
                        col_next   = '0;
                        row_next   = '0;
                        drain_next = (eff_h == HEIGHT_W'(1)) ? eff_w : eff_w + WW'(1);
                    end
                    else if (({1'b0, col_reg} + WW'(1)) >= eff_w)
                    begin
                        col_next = '0;
                        row_next = row_reg + HEIGHT_W'(1);
                    end
                    else
                    begin
                        col_next = col_reg + CW'(1);
                    end
                end
            end
            MODE_DRAIN:
            begin
                // Every request now flushes one pending result, whatever its opcode.
                if (accept)
                begin
                    q_push     = 1'b1;
                    q_data.op  = OP_DRAIN;
                    drain_next = drain_reg - WW'(1);
                    if (drain_reg == WW'(1))
                    begin
                        mode_next = MODE_FILL;
                    end
                end
            end
            default:
            begin
                mode_next = MODE_FILL;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_FILL;
            col_reg   <= '0;
            row_reg   <= '0;
            drain_reg <= '0;
        end
        else if (clear)
        begin
            mode_reg  <= MODE_FILL;
            col_reg   <= '0;
            row_reg   <= '0;
            drain_reg <= '0;
        end
        else
        begin
            mode_reg  <= mode_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            drain_reg <= drain_next;
        end
    end

endmodule

// ===== hdl/bblur_div.sv =====
module bblur_div (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  bblur_pkg::div_req_t                    req,
    output logic                                   done,
    output logic [2:0][bblur_pkg::QUO_W-1:0]       quo
);
    import bblur_pkg::*;

    localparam int STEP_W = $clog2(QUO_W);

    logic [2:0][NUM_W-1:0] rem_reg, rem_next;
    logic [2:0][QUO_W-1:0] quo_reg, quo_next;
    logic [NUM_W-1:0]      dsh_reg, dsh_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;

    assign done = done_reg;
    assign quo  = quo_reg;

    // Restoring division of (2*sum + cnt) by 2*cnt, one quotient bit per cycle.
    // The quotient always fits in eight bits because each sum is at most 255*cnt.
    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsh_next  = dsh_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            for (int i = 0; i < 3; i++)
            begin
                rem_next[i] = NUM_W'({req.sum[i], 1'b0}) + NUM_W'(req.cnt);
            end
            quo_next  = '0;
            dsh_next  = NUM_W'({req.cnt, 1'b0}) << (QUO_W - 1);
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (rem_reg[i] >= dsh_reg)
                begin
                    rem_next[i] = rem_reg[i] - dsh_reg;
                    quo_next[i] = {quo_reg[i][QUO_W-2:0], 1'b1};
                end
                else
                begin
                    quo_next[i] = {quo_reg[i][QUO_W-2:0], 1'b0};
                end
            end
            dsh_next  = dsh_reg >> 1;
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(QUO_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsh_reg <= dsh_next;
    end

endmodule

// ===== hdl/bblur_back.sv =====
module bblur_back #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          clear,
    input  logic [$clog2(MAX_WIDTH):0]    eff_w,
    input  logic [bblur_pkg::HEIGHT_W-1:0] eff_h,
    input  logic                          req_empty,
    input  bblur_pkg::req_t               req,
    output logic                          req_pop,
    input  logic                          res_full,
    output logic                          res_push,
    output bblur_pkg::result_t            res_data
);
    import bblur_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = CW + 1;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_READ  = 5'b00010,
        ST_SHIFT = 5'b00100,
        ST_SUM   = 5'b01000,
        ST_DIV   = 5'b10000
    } state_t;

    state_t           state_reg, state_next;
    logic [ROW_W-1:0] ir_reg, ir_next;
    logic [CW-1:0]    ic_reg, ic_next;
    op_t              op_reg;
    pixel_t           px_reg;
    logic [2:0]       rm_reg, cm_reg;
    logic             last_reg;

    pixel_t           older_mem [MAX_WIDTH];
    pixel_t           newer_mem [MAX_WIDTH];
    pixel_t           older_q;
    pixel_t           newer_q;
    pixel_t           win_reg [3][3];

    logic             rd_en;
    logic             wr_en;
    logic             shift_en;
    logic             div_start;
    logic             div_done;
    logic [2:0][QUO_W-1:0] div_quo;
    div_req_t         div_req;

    logic [ROW_W-1:0] h_ext;
    logic             e0, e1;
    logic [2:0]       rm0, cm0, rm1, cm1;
    logic             frame_last;

    assign h_ext = ROW_W'(eff_h);

    // Column-zero positions finish the previous row's right edge; the window has
    // already shifted, so that edge sits in window columns zero and one.
    assign e0  = (ic_reg == '0) && (ir_reg >= ROW_W'(2));
    assign rm0 = {(ir_reg - ROW_W'(1)) < h_ext, 1'b1, ir_reg >= ROW_W'(3)};
    assign cm0 = {1'b0, 1'b1, eff_w >= WW'(2)};
    assign e1  = (ic_reg != '0) && (ir_reg != '0);
    assign rm1 = {ir_reg < h_ext, 1'b1, ir_reg >= ROW_W'(2)};
    assign cm1 = {1'b1, 1'b1, {1'b0, ic_reg} >= WW'(2)};
    assign frame_last = e0 && (ir_reg == h_ext + ROW_W'(1));

    always_comb
    begin
        state_next = state_reg;
        ir_next    = ir_reg;
        ic_next    = ic_reg;
        req_pop    = 1'b0;
        rd_en      = 1'b0;
        wr_en      = 1'b0;
        shift_en   = 1'b0;
        div_start  = 1'b0;
        res_push   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!req_empty && !res_full)
                begin
                    req_pop    = 1'b1;
                    rd_en      = 1'b1;
                    state_next = ST_SHIFT;
                end
            end
            ST_READ:
            begin
                rd_en      = 1'b1;
                state_next = ST_SHIFT;
            end
            ST_SHIFT:
            begin
                shift_en = 1'b1;
                wr_en    = (op_reg == OP_PIXEL);
                if (frame_last)
                begin
                    ir_next = '0;
                    ic_next = '0;
                end
                else if (({1'b0, ic_reg} + WW'(1)) >= eff_w)
                begin
                    ic_next = '0;
                    ir_next = ir_reg + ROW_W'(1);
                end
                else
                begin
                    ic_next = ic_reg + CW'(1);
                end
                if (e0 || e1)
                begin
                    state_next = ST_SUM;
                end
                else if (op_reg == OP_DRAIN)
                begin
                    // A one-row frame has one position that yields nothing; step past it.
                    state_next = ST_READ;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SUM:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    res_push   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ir_reg    <= '0;
            ic_reg    <= '0;
        end
        else if (clear)
        begin
            state_reg <= ST_IDLE;
            ir_reg    <= '0;
            ic_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ir_reg    <= ir_next;
            ic_reg    <= ic_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_pop)
        begin
            op_reg <= req.op;
            px_reg <= req.px;
        end
        if (shift_en)
        begin
            rm_reg   <= e0 ? rm0 : rm1;
            cm_reg   <= e0 ? cm0 : cm1;
            last_reg <= frame_last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            older_q <= older_mem[ic_reg];
            newer_q <= newer_mem[ic_reg];
        end
        if (wr_en)
        begin
            older_mem[ic_reg] <= newer_q;
            newer_mem[ic_reg] <= px_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    win_reg[r][c] <= '0;
                end
            end
        end
        else if (shift_en)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win_reg[r][0] <= win_reg[r][1];
                win_reg[r][1] <= win_reg[r][2];
            end
            win_reg[0][2] <= older_q;
            win_reg[1][2] <= newer_q;
            win_reg[2][2] <= (op_reg == OP_PIXEL) ? px_reg : '0;
        end
    end

    always_comb
    begin
        div_req = '0;
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                if (rm_reg[r] && cm_reg[c])
                begin
                    div_req.sum[2] = div_req.sum[2] + SUM_W'(win_reg[r][c].red);
                    div_req.sum[1] = div_req.sum[1] + SUM_W'(win_reg[r][c].green);
                    div_req.sum[0] = div_req.sum[0] + SUM_W'(win_reg[r][c].blue);
                    div_req.cnt    = div_req.cnt + CNT_W'(1);
                end
            end
        end
    end

    bblur_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .req   (div_req),
        .done  (div_done),
        .quo   (div_quo)
    );

    assign res_data = '{px: pixel_t'(div_quo), frame_end: last_reg};

endmodule

// ===== hdl/box_blur_3x3_edge_shrink.sv =====
// Channel   Direction  Handshake            Payload
// input     in         push / full          opcode, red_in, green_in, blue_in
// result    out        pop / empty          red_out, green_out, blue_out, frame_end
// config    in         cfg_we               cfg_addr, cfg_wdata
//
// Requests are taken every cycle while the four-entry request queue has room.
// The back end handles one request at a time: it pops and reads the line stores,
// shifts the window, sums it and runs the 8-step divider for a request that yields a
// result. A pixel that yields no result is only popped, read and shifted in.
// Reset clears all control state at once; there is no clearing pass over the line stores.
// The front end stalls only on a full request queue, the back end only on a full result queue.
module box_blur_3x3_edge_shrink #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic                              opcode,
    input  logic [7:0]                        red_in,
    input  logic [7:0]                        green_in,
    input  logic [7:0]                        blue_in,
    output logic                              empty,
    input  logic                              pop,
    output logic [7:0]                        red_out,
    output logic [7:0]                        green_out,
    output logic [7:0]                        blue_out,
    output logic                              frame_end,
    input  logic                              cfg_we,
    input  logic                              cfg_addr,
    input  logic [bblur_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import bblur_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = CW + 1;

    logic [WIDTH_REG_W-1:0] frame_width_reg;
    logic [HEIGHT_W-1:0]    frame_height_reg;
    logic [WW-1:0]          eff_w;
    logic [HEIGHT_W-1:0]    eff_h;

    logic    q_full, q_empty, q_push, q_pop;
    req_t    q_wdata, q_rdata;
    logic    r_full, r_push;
    result_t r_wdata, r_rdata;
    pixel_t  in_px;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= WIDTH_RESET;
            frame_height_reg <= HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_wdata[WIDTH_REG_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_wdata[HEIGHT_W-1:0];
                default:          frame_height_reg <= frame_height_reg;
            endcase
        end
    end

    always_comb
    begin
        if (frame_width_reg == '0)
        begin
            eff_w = WW'(1);
        end
        else if (32'(frame_width_reg) > 32'(MAX_WIDTH))
        begin
            eff_w = WW'(MAX_WIDTH);
        end
        else
        begin
            eff_w = WW'(frame_width_reg);
        end
        eff_h = (frame_height_reg == '0) ? HEIGHT_W'(1) : frame_height_reg;
    end

    assign in_px = '{red: red_in, green: green_in, blue: blue_in};

    bblur_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .clear  (cfg_we),
        .eff_w  (eff_w),
        .eff_h  (eff_h),
        .push   (push),
        .opcode (op_t'(opcode)),
        .px     (in_px),
        .full   (full),
        .q_full (q_full),
        .q_push (q_push),
        .q_data (q_wdata)
    );

    bblur_fifo #(.WIDTH($bits(req_t)), .DEPTH(4)) u_req_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    bblur_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (cfg_we),
        .eff_w     (eff_w),
        .eff_h     (eff_h),
        .req_empty (q_empty),
        .req       (q_rdata),
        .req_pop   (q_pop),
        .res_full  (r_full),
        .res_push  (r_push),
        .res_data  (r_wdata)
    );

    bblur_fifo #(.WIDTH($bits(result_t)), .DEPTH(2)) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (r_push),
        .wdata (r_wdata),
        .full  (r_full),
        .pop   (pop),
        .rdata (r_rdata),
        .empty (empty)
    );

    assign red_out   = r_rdata.px.red;
    assign green_out = r_rdata.px.green;
    assign blue_out  = r_rdata.px.blue;
    assign frame_end = r_rdata.frame_end;

endmodule

// ===== hdl/bblur_checker.sv =====
module bblur_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       full,
    input logic       empty,
    input logic       pop,
    input logic [7:0] red_out,
    input logic [7:0] green_out,
    input logic [7:0] blue_out,
    input logic       frame_end
);

    // Both queues come out of reset empty.
    a_reset_state: assert property (@(posedge clk)
        !rst_n |=> empty && !full)
        else $error("queues not empty during reset");

    // Results leave the back end many cycles apart, so a lone result that is
    // taken leaves the result queue empty.
    a_result_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && pop && $past(empty) |=> empty)
        else $error("two results produced in consecutive cycles");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable({red_out, green_out, blue_out, frame_end}))
        else $error("waiting result changed before it was taken");

endmodule

bind box_blur_3x3_edge_shrink bblur_checker u_bblur_checker (.*);

// ===== tb/box_blur_3x3_edge_shrink_check.sv =====
module box_blur_3x3_edge_shrink_check
    import bblur_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  logic                  full,
    input  logic                  opcode,
    input  logic [7:0]            red_in,
    input  logic [7:0]            green_in,
    input  logic [7:0]            blue_in,
    input  logic                  empty,
    input  logic                  pop,
    input  logic [7:0]            red_out,
    input  logic [7:0]            green_out,
    input  logic [7:0]            blue_out,
    input  logic                  frame_end,
    input  logic                  cfg_we,
    input  logic                  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output int                    errors,
    output int                    pending
);
    timeunit 1ns;
    timeprecision 1ps;

    pixel_t                 line_old [MAX_WIDTH];
    pixel_t                 line_new [MAX_WIDTH];
    pixel_t                 win [3][3];
    logic [WIDTH_REG_W-1:0] width_reg;
    logic [HEIGHT_W-1:0]    height_reg;
    int                     in_r, in_c, out_r, out_c;
    result_t                blur_q[$];

    function automatic int eff_w();
        if (width_reg == 0) return 1;
        if (width_reg > MAX_WIDTH) return MAX_WIDTH;
        return int'(width_reg);
    endfunction

    function automatic int eff_h();
        return (height_reg == 0) ? 1 : int'(height_reg);
    endfunction

    function automatic logic [7:0] rounded(int s, int n);
        return 8'((2 * s + n) / (2 * n));
    endfunction

    // Queue the mean over the window cells picked by the row and column masks.
    task automatic queue_mean(input int rm, input int cm, input int orow, input int ocol,
                              output int got);
        int      sr, sg, sb, n;
        result_t res;
        sr = 0; sg = 0; sb = 0; n = 0;
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                if (rm[r] && cm[c])
                begin
                    sr += win[r][c].red;
                    sg += win[r][c].green;
                    sb += win[r][c].blue;
                    n++;
                end
        if (n == 0) n = 1;
        res.px.red   = rounded(sr, n);
        res.px.green = rounded(sg, n);
        res.px.blue  = rounded(sb, n);
        res.frame_end = (orow == eff_h() - 1) && (ocol == eff_w() - 1);
        blur_q.push_back(res);
        if (res.frame_end)
        begin
            out_r = 0;
            out_c = 0;
        end
        else if (ocol + 1 >= eff_w())
        begin
            out_r = orow + 1;
            out_c = 0;
        end
        else
        begin
            out_r = orow;
            out_c = ocol + 1;
        end
        got = res.frame_end ? 2 : 1;
    endtask

    // Move the stream on by one position, either a real pixel or one past the frame.
    task automatic shift_in(input pixel_t px, input bit real_px, output int got);
        int w, h, r_i, c_i, rm, cm;
        w = eff_w();
        h = eff_h();
        r_i = in_r;
        c_i = in_c;
        got = 0;
        if (c_i >= w) c_i = w - 1;
        if (c_i == 0 && r_i >= 2)
        begin
            rm = (r_i >= 3 ? 1 : 0) | 2 | (r_i - 1 < h ? 4 : 0);
            cm = 4 | (w >= 2 ? 2 : 0);
            queue_mean(rm, cm, r_i - 2, w - 1, got);
        end
        for (int r = 0; r < 3; r++)
        begin
            win[r][0] = win[r][1];
            win[r][1] = win[r][2];
        end
        win[0][2] = line_old[c_i];
        win[1][2] = line_new[c_i];
        win[2][2] = px;
        if (real_px)
        begin
            line_old[c_i] = line_new[c_i];
            line_new[c_i] = px;
        end
        if (c_i >= 1 && r_i >= 1)
        begin
            rm = (r_i >= 2 ? 1 : 0) | 2 | (r_i < h ? 4 : 0);
            cm = (c_i >= 2 ? 1 : 0) | 6;
            queue_mean(rm, cm, r_i - 1, c_i - 1, got);
        end
        c_i++;
        if (c_i >= w)
        begin
            c_i = 0;
            r_i++;
        end
        in_r = r_i;
        in_c = c_i;
        if (got == 2)
        begin
            in_r = 0;
            in_c = 0;
        end
    endtask

    task automatic take_request(input op_t op, input pixel_t px);
        int got;
        if (in_r >= eff_h())
        begin
            // Flushing: any request moves on up to three virtual positions.
            got = 0;
            for (int i = 0; i < 3 && got == 0; i++)
            begin
                shift_in('0, 1'b0, got);
                if (in_r < eff_h()) break;
            end
        end
        else if (op == OP_PIXEL)
            shift_in(px, 1'b1, got);
    endtask

    initial
    begin
        for (int i = 0; i < MAX_WIDTH; i++)
        begin
            line_old[i] = '0;
            line_new[i] = '0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                    win[r][c] = '0;
            width_reg  = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            in_r = 0; in_c = 0; out_r = 0; out_c = 0;
            errors  = 0;
            pending = 0;
            blur_q.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_reg_t'(cfg_addr) == REG_FRAME_WIDTH)
                    width_reg = cfg_wdata[WIDTH_REG_W-1:0];
                else
                    height_reg = cfg_wdata[HEIGHT_W-1:0];
                in_r = 0; in_c = 0; out_r = 0; out_c = 0;
            end
            if (push && !full)
                take_request(op_t'(opcode), {red_in, green_in, blue_in});
            if (pop && !empty)
            begin
                if (blur_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result %h %h %h end=%b",
                                 red_out, green_out, blue_out, frame_end);
                end
                else
                begin
                    result_t want;
                    want = blur_q.pop_front();
                    if (want.px.red !== red_out || want.px.green !== green_out ||
                        want.px.blue !== blue_out || want.frame_end !== frame_end)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: expected %h %h %h end=%b, got %h %h %h end=%b",
                                     want.px.red, want.px.green, want.px.blue,
                                     want.frame_end, red_out, green_out, blue_out,
                                     frame_end);
                    end
                end
            end
            pending = blur_q.size();
        end
    end

endmodule

// ===== tb/box_blur_3x3_edge_shrink_test.sv =====
module box_blur_3x3_edge_shrink_test;
    import bblur_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 5000;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  push = 1'b0;
    logic                  full;
    logic                  opcode = 1'b0;
    logic [7:0]            red_in = '0;
    logic [7:0]            green_in = '0;
    logic [7:0]            blue_in = '0;
    logic                  empty;
    logic                  pop = 1'b0;
    logic [7:0]            red_out, green_out, blue_out;
    logic                  frame_end;
    logic                  cfg_we = 1'b0;
    logic                  cfg_addr = 1'b0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    int                    errors, pending;
    int                    burst_left = 0;
    int                    sent = 0;
    int                    idle_cycles = 0;
    int                    stall_left = 0;
    int                    pop_mode = 0;

    always #2 clk = ~clk;

    box_blur_3x3_edge_shrink DUT (.*);

    box_blur_3x3_edge_shrink_check checker_i (.*);

    // The receiver alternates between free running and heavy stalling.
    always @(posedge clk)
    begin
        if ($urandom_range(0, 199) == 0) pop_mode <= $urandom_range(0, 2);
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            pop <= 1'b0;
        end
        else if (pop_mode != 0 && $urandom_range(0, 9) < 2 * pop_mode)
        begin
            stall_left <= $urandom_range(0, 12);
            pop <= 1'b0;
        end
        else
            pop <= 1'b1;
    end

    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic pixel_t any_pixel(bit extreme);
        pixel_t p;
        p = pixel_t'($urandom);
        if (extreme)
        begin
            p.red   = p.red[0]   ? 8'hff : 8'h00;
            p.green = p.green[0] ? 8'hff : 8'h00;
            p.blue  = p.blue[0]  ? 8'hff : 8'h00;
        end
        return p;
    endfunction

    task automatic send(input op_t op, input pixel_t px);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = $urandom_range(0, 5);
            if (gap > 0)
            begin
                push <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        push     <= 1'b1;
        opcode   <= op;
        red_in   <= px.red;
        green_in <= px.green;
        blue_in  <= px.blue;
        do @(posedge clk); while (full);
        sent++;
    endtask

    // Writes both size registers once the block has delivered everything.
    task automatic set_size(input int w, input int h);
        push <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        repeat (20) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_FRAME_WIDTH;
        cfg_wdata <= CFG_DATA_W'(w);
        @(posedge clk);
        cfg_addr  <= REG_FRAME_HEIGHT;
        cfg_wdata <= CFG_DATA_W'(h);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // One frame with stray drain requests mixed in, then flush requests of mixed kind.
    task automatic run_frame(input int w, input int h, input bit extreme);
        int n;
        n = 0;
        while (n < w * h)
        begin
            if ($urandom_range(0, 7) == 0)
                send(OP_DRAIN, any_pixel(extreme));
            else
            begin
                send(OP_PIXEL, any_pixel(extreme));
                n++;
            end
        end
        for (int i = 0; i < w + 1; i++)
            send(op_t'($urandom_range(0, 1)), any_pixel(extreme));
        send(OP_DRAIN, any_pixel(extreme));
    endtask

    initial
    begin
        int w, h, frames;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_size(1, 1);
        run_frame(1, 1, 1'b1);
        set_size(3, 3);
        run_frame(3, 3, 1'b1);
        // Zero height acts as one row, zero width as one column.
        set_size(3, 0);
        run_frame(3, 1, 1'b0);
        set_size(0, 2);
        run_frame(1, 2, 1'b0);
        // A frame abandoned in its first row by a register write.
        set_size(5, 4);
        repeat (3) send(OP_PIXEL, any_pixel(1'b0));
        set_size(2, 2);
        run_frame(2, 2, 1'b1);
        // Width written above the limit; the frame is abandoned in its first row.
        set_size(2047, 2);
        repeat (40) send(OP_PIXEL, any_pixel(1'b0));
        // A frame 4096 rows tall, abandoned after its first rows.
        set_size(1, 4096);
        repeat (60) send(OP_PIXEL, any_pixel(1'b0));

        while (sent < 550)
        begin
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            h = $urandom_range(1, 6);
            set_size(w, h);
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(0, w - 1)) send(OP_PIXEL, any_pixel(1'b0));
            else
            begin
                frames = $urandom_range(1, 3);
                repeat (frames) run_frame(w, h, $urandom_range(0, 4) == 0);
            end
        end

        push <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        repeat (40) @(posedge clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
